// File: rtl/core/mpat_pkg.sv
`default_nettype none

package mpat_pkg;

  // fixed field widths
  localparam int unsigned KEY_IN_W    = 48;
  localparam int unsigned LIFE_W      = 8;
  localparam int unsigned OUTCOME_W   = 2;
  localparam int unsigned SLOT_W      = 5;
  localparam int unsigned ALIVE_W     = 6;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned ALIVE_MAX   = 63;

  // parameter defaults
  localparam int unsigned ENTRIES_DEF   = 32;
  localparam int unsigned KEY_BYTES_DEF = 6;

  // refresh life after reset
  localparam logic [LIFE_W-1:0] LIFE_RESET = 8'd60;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_REFRESH = 2'd0,
    OUT_INSERT  = 2'd1,
    OUT_DROP    = 2'd2
  } outcome_e;

  // outcome sits in the lowest bits
  typedef struct packed {
    logic [ALIVE_W-1:0] alive_count;
    logic [SLOT_W-1:0]  slot_index;
    outcome_e           outcome;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/mac_presence_aging_table.sv
`default_nettype none

// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata[47:0] mac_key
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata[1:0] outcome, [6:2] slot_index,
//                                              [12:7] alive_count, [15:13] zero
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_data_i[7:0] refresh_life
//
// each request runs through an accept state, one pass over all ENTRIES entries of
// the key and life memories (one read port each, registered read data), and a
// finish state that writes the chosen slot
// no clearing pass after reset: the first pass treats every read as zero and
// rewrites each entry, so the memories are valid once the first request is done
// the result sits in an output register; a new request is taken while it waits,
// the finish cycle of the next request holds until that register is free

module mac_presence_aging_table #(
  parameter int unsigned ENTRIES   = mpat_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BYTES = mpat_pkg::KEY_BYTES_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // configuration write
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire [mpat_pkg::LIFE_W-1:0]          cfg_data_i,    // refresh_life
  // request stream
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire [mpat_pkg::KEY_IN_W-1:0]        s_axis_tdata,  // mac_key
  // result stream
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [mpat_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // outcome, slot_index,
                                                             // alive_count
);

  localparam int unsigned KW = KEY_BYTES * 8;
  localparam int unsigned IW = $clog2(ENTRIES);

  // refresh life register
  logic [mpat_pkg::LIFE_W-1:0] life_q, life_d;

  // output register
  logic           out_valid_q, out_valid_d;
  mpat_pkg::res_t out_data_q, out_data_d;

  // engine result handshake
  logic           res_valid, res_ready;
  mpat_pkg::res_t res;

  // memory ports
  logic [IW-1:0]              raddr, waddr;
  logic [KW-1:0]              key_rdata, key_wdata;
  logic [mpat_pkg::LIFE_W-1:0] life_rdata, life_wdata;
  logic                       key_we, life_we;

  assign cfg_ready_o = 1'b1;
  assign life_d      = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : life_q;

  // output register takes a new result when empty or being drained
  assign res_ready   = !out_valid_q || m_axis_tready;
  assign out_valid_d = res_valid ? 1'b1 : (out_valid_q && !m_axis_tready);
  assign out_data_d  = (res_valid && res_ready) ? res : out_data_q;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = mpat_pkg::OUT_TDATA_W'(out_data_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      life_q      <= mpat_pkg::LIFE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      life_q      <= life_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  // stored keys
  mpat_ram #(
    .WIDTH (KW),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (waddr),
    .wdata_i (key_wdata),
    .raddr_i (raddr),
    .rdata_o (key_rdata)
  );

  // life counters
  mpat_ram #(
    .WIDTH (mpat_pkg::LIFE_W),
    .DEPTH (ENTRIES)
  ) u_life_ram (
    .clk_i   (clk_i),
    .we_i    (life_we),
    .waddr_i (waddr),
    .wdata_i (life_wdata),
    .raddr_i (raddr),
    .rdata_o (life_rdata)
  );

  // search, age and update sequencer
  mpat_engine #(
    .ENTRIES   (ENTRIES),
    .KEY_BYTES (KEY_BYTES)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_key_i     (s_axis_tdata),
    .life_i       (life_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .raddr_o      (raddr),
    .key_rdata_i  (key_rdata),
    .life_rdata_i (life_rdata),
    .waddr_o      (waddr),
    .key_we_o     (key_we),
    .key_wdata_o  (key_wdata),
    .life_we_o    (life_we),
    .life_wdata_o (life_wdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/mpat_ram.sv
`default_nettype none

module mpat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(DEPTH)-1:0] waddr_i,
  input  wire [WIDTH-1:0]         wdata_i,
  input  wire [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/mpat_engine.sv
`default_nettype none

module mpat_engine #(
  parameter int unsigned ENTRIES   = mpat_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BYTES = mpat_pkg::KEY_BYTES_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // request side
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire [mpat_pkg::KEY_IN_W-1:0]     in_key_i,
  input  wire [mpat_pkg::LIFE_W-1:0]       life_i,
  // result side
  output logic                             res_valid_o,
  input  wire                              res_ready_i,
  output mpat_pkg::res_t                   res_o,
  // memory ports
  output logic [$clog2(ENTRIES)-1:0]       raddr_o,
  input  wire [KEY_BYTES*8-1:0]            key_rdata_i,
  input  wire [mpat_pkg::LIFE_W-1:0]       life_rdata_i,
  output logic [$clog2(ENTRIES)-1:0]       waddr_o,
  output logic                             key_we_o,
  output logic [KEY_BYTES*8-1:0]           key_wdata_o,
  output logic                             life_we_o,
  output logic [mpat_pkg::LIFE_W-1:0]      life_wdata_o
);

  localparam int unsigned KW = KEY_BYTES * 8;
  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned LW = mpat_pkg::LIFE_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [KW-1:0] key_q, key_d;
  logic          cleared_q, cleared_d;
  logic          match_q, match_d;
  logic [IW-1:0] match_slot_q, match_slot_d;
  logic          match_nz_q, match_nz_d;
  logic          free_q, free_d;
  logic [IW-1:0] free_slot_q, free_slot_d;
  logic [CW-1:0] alive_q, alive_d;

  logic          in_fire, res_fire, proc;
  logic [IW-1:0] paddr;
  logic [KW-1:0] key_rd;
  logic [LW-1:0] life_rd, aged, life_new;
  logic          found;
  logic [IW-1:0] slot;
  logic [SW-1:0] alive_sum;
  logic [mpat_pkg::ALIVE_W-1:0] alive_sat;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_FIN);
  assign in_fire     = in_valid_i && in_ready_o;
  assign res_fire    = res_valid_o && res_ready_i;

  // entry under processing trails the read address by one
  assign proc    = (state_q == ST_SCAN) && (cnt_q != '0);
  assign paddr   = IW'(cnt_q - CW'(1));
  assign raddr_o = (cnt_q < CW'(ENTRIES)) ? cnt_q[IW-1:0] : '0;

  // until the first pass has rewritten every entry, memory reads as zero
  assign key_rd  = cleared_q ? key_rdata_i : '0;
  assign life_rd = cleared_q ? life_rdata_i : '0;
  assign aged    = (life_rd == '0) ? '0 : life_rd - LW'(1);

  assign life_new = (life_i == '0) ? '0 : life_i - LW'(1);
  assign found    = match_q || free_q;
  assign slot     = match_q ? match_slot_q : free_slot_q;

  // patch the chosen slot's contribution into the pass count
  assign alive_sum = SW'(alive_q) - SW'(match_q && match_nz_q)
                   + SW'(found && (life_i > LW'(1)));
  assign alive_sat = (16'(alive_sum) > 16'(mpat_pkg::ALIVE_MAX))
                   ? mpat_pkg::ALIVE_W'(mpat_pkg::ALIVE_MAX)
                   : mpat_pkg::ALIVE_W'(alive_sum);

  always_comb begin
    res_o.alive_count = alive_sat;
    res_o.slot_index  = found ? mpat_pkg::SLOT_W'(slot) : '0;
    if (match_q) begin
      res_o.outcome = mpat_pkg::OUT_REFRESH;
    end else if (free_q) begin
      res_o.outcome = mpat_pkg::OUT_INSERT;
    end else begin
      res_o.outcome = mpat_pkg::OUT_DROP;
    end
  end

  // memory writes: age-back during the pass, slot update at finish
  always_comb begin
    waddr_o      = paddr;
    key_we_o     = 1'b0;
    life_we_o    = 1'b0;
    key_wdata_o  = key_rd;
    life_wdata_o = aged;
    if (proc) begin
      key_we_o  = 1'b1;
      life_we_o = 1'b1;
    end else if (res_fire && found) begin
      waddr_o      = slot;
      key_we_o     = 1'b1;
      life_we_o    = 1'b1;
      key_wdata_o  = key_q;
      life_wdata_o = life_new;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    key_d        = key_q;
    cleared_d    = cleared_q;
    match_d      = match_q;
    match_slot_d = match_slot_q;
    match_nz_d   = match_nz_q;
    free_d       = free_q;
    free_slot_d  = free_slot_q;
    alive_d      = alive_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          key_d   = KW'(in_key_i);
          cnt_d   = '0;
          match_d = 1'b0;
          free_d  = 1'b0;
          alive_d = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (proc) begin
          if (!match_q && (key_rd == key_q)) begin
            match_d      = 1'b1;
            match_slot_d = paddr;
            match_nz_d   = (aged != '0);
          end
          if (!free_q && (life_rd == '0)) begin
            free_d      = 1'b1;
            free_slot_d = paddr;
          end
          alive_d = alive_q + CW'(aged != '0);
        end
        // counter stops at the table depth
        if (cnt_q == CW'(ENTRIES)) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_FIN: begin
        if (res_fire) begin
          cleared_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      cleared_q <= 1'b0;
      match_q   <= 1'b0;
      free_q    <= 1'b0;
      alive_q   <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cleared_q <= cleared_d;
      match_q   <= match_d;
      free_q    <= free_d;
      alive_q   <= alive_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    match_slot_q <= match_slot_d;
    match_nz_q   <= match_nz_d;
    free_slot_q  <= free_slot_d;
  end

`ifndef SYNTHESIS
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_SCAN) && (cnt_q == '0))
    else $error("scan did not start after accepted request");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(ENTRIES))
    else $error("scan counter past table depth");

  a_alive_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (16'(alive_sum) <= 16'(ENTRIES)))
    else $error("live count exceeds table depth");

  a_cleared_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cleared_q |=> cleared_q)
    else $error("initial clear flag fell");

  a_scan_writes_only_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (life_we_o && !proc) |-> (res_fire && found))
    else $error("life write outside pass or slot update");
`endif

endmodule

`default_nettype wire

// File: tb/mac_presence_aging_table_tb.sv
// expected behavior of the aging presence table, kept in step with every accepted request
class presence_tracker;
  logic [mpat_pkg::KEY_IN_W-1:0] slot_key [mpat_pkg::ENTRIES_DEF];
  logic [mpat_pkg::LIFE_W-1:0]   slot_life[mpat_pkg::ENTRIES_DEF];
  logic [mpat_pkg::LIFE_W-1:0]   refresh_life;
  mpat_pkg::res_t                expected_q[$];
  int                            errors;

  function new();
    for (int i = 0; i < mpat_pkg::ENTRIES_DEF; i++) begin
      slot_key[i]  = '0;
      slot_life[i] = '0;
    end
    refresh_life = mpat_pkg::LIFE_RESET;
    errors       = 0;
  endfunction

  function void set_refresh(logic [mpat_pkg::LIFE_W-1:0] value);
    refresh_life = value;
  endfunction

  function int outstanding();
    return expected_q.size();
  endfunction

  // search, refresh or insert, then age every live slot by one
  function void observe_key(logic [mpat_pkg::KEY_IN_W-1:0] mac_key);
    logic [mpat_pkg::KEY_IN_W-1:0] key_mask;
    logic [mpat_pkg::KEY_IN_W-1:0] masked;
    mpat_pkg::res_t                r;
    bit                            found;
    int                            slot;
    int                            alive;
    key_mask = '1;
    if (mpat_pkg::KEY_BYTES_DEF < 6)
      key_mask = (48'd1 << (8 * mpat_pkg::KEY_BYTES_DEF)) - 48'd1;
    masked    = mac_key & key_mask;
    found     = 1'b0;
    slot      = 0;
    alive     = 0;
    r.outcome = mpat_pkg::OUT_DROP;
    // expired slots take part in the search too
    for (int i = 0; i < mpat_pkg::ENTRIES_DEF; i++) begin
      if (!found && slot_key[i] == masked) begin
        found     = 1'b1;
        slot      = i;
        r.outcome = mpat_pkg::OUT_REFRESH;
      end
    end
    if (!found) begin
      for (int i = 0; i < mpat_pkg::ENTRIES_DEF; i++) begin
        if (!found && slot_life[i] == '0) begin
          found       = 1'b1;
          slot        = i;
          r.outcome   = mpat_pkg::OUT_INSERT;
          slot_key[i] = masked;
        end
      end
    end
    if (found)
      slot_life[slot] = refresh_life;
    for (int i = 0; i < mpat_pkg::ENTRIES_DEF; i++) begin
      if (slot_life[i] != '0) begin
        slot_life[i] = slot_life[i] - 1'b1;
        if (slot_life[i] != '0)
          alive++;
      end
    end
    r.slot_index  = found ? slot[mpat_pkg::SLOT_W-1:0] : '0;
    r.alive_count = (alive > mpat_pkg::ALIVE_MAX) ? mpat_pkg::ALIVE_MAX[mpat_pkg::ALIVE_W-1:0]
                                                  : alive[mpat_pkg::ALIVE_W-1:0];
    expected_q.push_back(r);
  endfunction

  function void compare_result(logic [mpat_pkg::OUT_TDATA_W-1:0] data);
    mpat_pkg::res_t want;
    mpat_pkg::res_t got;
    got = mpat_pkg::res_t'(data[$bits(mpat_pkg::res_t)-1:0]);
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("result with no pending request: tdata=%h", data);
      return;
    end
    want = expected_q.pop_front();
    if (got.outcome != want.outcome || got.slot_index != want.slot_index ||
        got.alive_count != want.alive_count) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected outcome=%0d slot=%0d alive=%0d, got outcome=%0d slot=%0d alive=%0d",
                 want.outcome, want.slot_index, want.alive_count,
                 got.outcome, got.slot_index, got.alive_count);
    end
  endfunction
endclass

module mac_presence_aging_table_tb;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                cfg_valid_i;
  logic                                cfg_ready_o;
  logic [mpat_pkg::LIFE_W-1:0]         cfg_data_i;
  logic                                s_axis_tvalid;
  logic                                s_axis_tready;
  logic [mpat_pkg::KEY_IN_W-1:0]       s_axis_tdata;   // mac_key
  logic                                m_axis_tvalid;
  logic                                m_axis_tready;
  logic [mpat_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;   // outcome, slot_index, alive_count

  presence_tracker                     tracker;

  // key pool for the current phase: repeated keys drive refresh, insert and fill-up
  logic [mpat_pkg::KEY_IN_W-1:0]       key_pool[64];
  int                                  pool_size;
  int                                  sent_count;
  int                                  got_count;
  int                                  hold_left;
  bit                                  held_once;

  mac_presence_aging_table uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // generous cutoff, far above the slowest legal run
  initial begin
    #(8 * 600000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random stalls, one long hold-off, and a stretch with no stalls
  initial begin
    m_axis_tready = 1'b0;
    got_count     = 0;
    hold_left     = 0;
    held_once     = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.compare_result(m_axis_tdata);
        got_count++;
      end
      if (!held_once && got_count == 300) begin
        held_once = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (got_count >= 500 && got_count < 700) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 32);
      end
    end
  end

  function automatic logic [mpat_pkg::KEY_IN_W-1:0] random_key();
    logic [63:0] w;
    w = {$urandom, $urandom};
    // zero bytes carry no special meaning, so plant some
    if ($urandom_range(3) == 0)
      w[8 * $urandom_range(5) +: 8] = 8'h00;
    return w[mpat_pkg::KEY_IN_W-1:0];
  endfunction

  function automatic logic [mpat_pkg::KEY_IN_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 80)
      return key_pool[$urandom_range(pool_size - 1)];
    else if (r < 88)
      return random_key();
    else if (r < 92)
      return '0;
    else if (r < 95)
      return '1;
    else
      return key_pool[$urandom_range(pool_size - 1)] ^ (48'd1 << $urandom_range(47));
  endfunction

  // offer one key, with random gaps outside the quiet stretch
  task automatic send_key(input logic [mpat_pkg::KEY_IN_W-1:0] mac_key);
    if (sent_count < 500 || sent_count >= 700) begin
      while ($urandom_range(99) < 32) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= mac_key;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.observe_key(mac_key);
    sent_count++;
  endtask

  // refresh life is only changed with the table idle
  task automatic write_life(input logic [mpat_pkg::LIFE_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.set_refresh(value);
  endtask

  task automatic run_phase(input logic [mpat_pkg::LIFE_W-1:0] life, input int items,
                           input int psize);
    write_life(life);
    pool_size = psize;
    for (int i = 0; i < psize; i++)
      key_pool[i] = random_key();
    repeat (items) send_key(pick_key());
  endtask

  initial begin
    tracker       = new();
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    sent_count    = 0;
    pool_size     = 1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero key right after reset matches slot 0, then field extremes
    send_key(48'h0000_0000_0000);
    send_key(48'hFFFF_FFFF_FFFF);
    send_key(48'hAAAA_AAAA_AAAA);
    send_key(48'h5555_5555_5555);
    send_key(48'hFFFF_FFFF_FFFF);
    send_key(48'h0000_0000_0001);
    send_key(48'h8000_0000_0000);
    send_key(48'h0012_0000_3400);

    // short life: the first key expires and is then refreshed in place
    write_life(8'd2);
    send_key(48'h0102_0304_0506);
    send_key(48'h0A0B_0C0D_0E0F);
    send_key(48'h0102_0304_0506);

    // zero life: the slot stays dead while outcomes are still reported
    write_life(8'd0);
    send_key(48'hDEAD_BEEF_0001);
    send_key(48'hDEAD_BEEF_0001);
    send_key(48'h0000_0000_0000);

    // random phases; long lives with large pools fill the table and force drops
    run_phase(8'd60, 150, 24);
    run_phase(8'd255, 220, 48);
    run_phase(8'd1, 90, 8);
    run_phase(8'd3, 100, 16);
    run_phase(8'($urandom_range(1, 255)), 240, 40);
    run_phase(8'd255, 200, 36);
    run_phase(8'($urandom_range(1, 255)), 180, 64);

    s_axis_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    // catch any stray result beyond the last expected one
    repeat (80) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/mpat_pkg.sv
rtl/core/mpat_ram.sv
rtl/core/mpat_engine.sv
rtl/core/mac_presence_aging_table.sv
tb/mac_presence_aging_table_tb.sv
